FILE: rtl/rbds_pkg.sv
// ----------------------------------------------------------------------------
// rbds_pkg: shared types and constants of the ring buffer deque
// Opcodes, status codes, field widths and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package rbds_pkg;

  localparam int DEPTH_DEF   = 64;
  localparam int CAP_W       = 7;
  localparam int CAP_RESET   = 64;
  localparam int FUNC_W      = 3;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int SLOT_OUT_W  = 6;
  localparam int FILL_W      = 7;
  localparam int OUT_DATA_W  = 48;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // word index of the capacity register, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_REAR  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_REAR   = 3'd3,
    FN_PEEK       = 3'd4,
    FN_SEARCH     = 3'd5,
    FN_CLEAR      = 3'd6
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch the accepted item
    logic exec;       // run the operation on the pointers and count
    logic rd_cap;     // capture the word read from the store
    logic srch_step;  // one step of the search walk
    logic out_load;   // move the result into the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_search;
    logic need_read;
    logic srch_done;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/rbds_ctrl.sv
// ----------------------------------------------------------------------------
// rbds_ctrl: operation sequencer of the ring buffer deque
// One-hot state machine that steps one item through execute, read, search
// and response phases.
// ----------------------------------------------------------------------------
module rbds_ctrl import rbds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_RDWT = 5'b00100,
    S_SRCH = 5'b01000,
    S_RESP = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (stat_i.is_search) begin
          state_d = S_SRCH;
        end else if (stat_i.need_read) begin
          state_d = S_RDWT;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RDWT: begin
        cmd_o.rd_cap = 1'b1;
        state_d      = S_RESP;
      end
      S_SRCH: begin
        cmd_o.srch_step = 1'b1;
        if (stat_i.srch_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/rbds_datapath.sv
// ----------------------------------------------------------------------------
// rbds_datapath: ring store, pointers and result registers of the deque
// Holds the store, head/tail/count, the capacity register, the search walk
// and the output register.
// ----------------------------------------------------------------------------
module rbds_datapath import rbds_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_cmd_t             cmd_i,
  output dp_stat_t              stat_o,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [VALUE_W-1:0]    value_i,
  input  logic                  cfg_we_i,
  input  logic [CAP_W-1:0]      cfg_wdata_i,
  output logic [PDATA_W-1:0]    cfg_rdata_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   out_status_o,
  output logic [VALUE_W-1:0]    out_data_o,
  output logic [SLOT_OUT_W-1:0] out_slot_o,
  output logic [FILL_W-1:0]     out_fill_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] CAP_RST = (CAP_RESET > DEPTH) ? CW'(DEPTH) : CW'(CAP_RESET);

  function automatic logic [PTR_W-1:0] step_up(logic [PTR_W-1:0] p, logic [CW-1:0] cap);
    logic [CW-1:0] nxt;
    nxt = CW'(p) + CW'(1);
    return (nxt >= cap) ? '0 : PTR_W'(nxt);
  endfunction

  function automatic logic [PTR_W-1:0] step_down(logic [PTR_W-1:0] p, logic [CW-1:0] cap);
    logic [CW-1:0] prv;
    prv = cap - CW'(1);
    return (p == '0) ? PTR_W'(prv) : p - PTR_W'(1);
  endfunction

  // store
  logic [VALUE_W-1:0] mem_q [DEPTH];
  logic [VALUE_W-1:0] rdata_q;
  logic               mem_we, mem_re;
  logic [PTR_W-1:0]   mem_waddr, mem_raddr;

  func_e              op_q, op_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]      cnt_q, cnt_d, cap_q, cap_d;
  status_e            res_status_q, res_status_d;
  logic [VALUE_W-1:0] res_data_q, res_data_d;
  logic [PTR_W-1:0]   res_slot_q, res_slot_d;
  logic [PTR_W-1:0]   scan_ptr_q, scan_ptr_d, pend_slot_q, pend_slot_d;
  logic [CW-1:0]      scan_cnt_q, scan_cnt_d;
  logic               pend_q, pend_d;
  logic               out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;
  logic [VALUE_W-1:0]    out_data_q, out_data_d;
  logic [SLOT_OUT_W-1:0] out_slot_q, out_slot_d;
  logic [FILL_W-1:0]     out_fill_q, out_fill_d;

  logic          is_full, is_empty, match_now, issue;
  logic [CW-1:0] cfg_v;

  assign is_full   = (cnt_q >= cap_q);
  assign is_empty  = (cnt_q == '0);
  assign match_now = pend_q && (rdata_q == val_q);
  assign issue     = !match_now && (scan_cnt_q != cnt_q);

  assign stat_o.is_search = (op_q == FN_SEARCH);
  assign stat_o.need_read = ((op_q == FN_POP_FRONT) || (op_q == FN_POP_REAR) ||
                             (op_q == FN_PEEK)) && !is_empty;
  assign stat_o.srch_done = match_now || (!pend_q && (scan_cnt_q == cnt_q));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // clamp the written capacity to 1..DEPTH
  always_comb begin
    cfg_v = CW'(cfg_wdata_i);
    if (cfg_v == '0) begin
      cfg_v = CW'(1);
    end else if (cfg_v > DEPTH_C) begin
      cfg_v = DEPTH_C;
    end
  end

  always_comb begin
    op_d         = op_q;
    val_d        = val_q;
    head_d       = head_q;
    tail_d       = tail_q;
    cnt_d        = cnt_q;
    cap_d        = cap_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_slot_d   = res_slot_q;
    scan_ptr_d   = scan_ptr_q;
    scan_cnt_d   = scan_cnt_q;
    pend_d       = pend_q;
    pend_slot_d  = pend_slot_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_slot_d   = out_slot_q;
    out_fill_d   = out_fill_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = tail_q;
    mem_raddr    = head_q;

    if (cmd_i.load) begin
      op_d  = func_e'(func_i);
      val_d = value_i;
    end

    if (cmd_i.exec) begin
      res_status_d = ST_OK;
      res_data_d   = '0;
      res_slot_d   = '0;
      case (op_q)
        FN_PUSH_REAR: begin
          if (is_full) begin
            res_status_d = ST_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = tail_q;
            tail_d    = step_up(tail_q, cap_q);
            cnt_d     = cnt_q + CW'(1);
          end
        end
        FN_PUSH_FRONT: begin
          if (is_full) begin
            res_status_d = ST_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = step_down(head_q, cap_q);
            head_d    = step_down(head_q, cap_q);
            cnt_d     = cnt_q + CW'(1);
          end
        end
        FN_POP_FRONT: begin
          if (is_empty) begin
            res_status_d = ST_EMPTY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = head_q;
            head_d    = step_up(head_q, cap_q);
            cnt_d     = cnt_q - CW'(1);
          end
        end
        FN_POP_REAR: begin
          if (is_empty) begin
            res_status_d = ST_EMPTY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = step_down(tail_q, cap_q);
            tail_d    = step_down(tail_q, cap_q);
            cnt_d     = cnt_q - CW'(1);
          end
        end
        FN_PEEK: begin
          if (is_empty) begin
            res_status_d = ST_EMPTY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = head_q;
          end
        end
        FN_SEARCH: begin
          scan_ptr_d = head_q;
          scan_cnt_d = '0;
          pend_d     = 1'b0;
        end
        FN_CLEAR: begin
          head_d = '0;
          tail_d = '0;
          cnt_d  = '0;
        end
        default: ;
      endcase
    end

    if (cmd_i.rd_cap) begin
      res_data_d = rdata_q;
    end

    // walk from the front: issue one read a cycle, compare it the next
    if (cmd_i.srch_step) begin
      pend_d      = issue;
      pend_slot_d = scan_ptr_q;
      if (issue) begin
        mem_re     = 1'b1;
        mem_raddr  = scan_ptr_q;
        scan_ptr_d = step_up(scan_ptr_q, cap_q);
        scan_cnt_d = scan_cnt_q + CW'(1);
      end
      if (match_now) begin
        res_slot_d = pend_slot_q;
      end else if (!pend_q && (scan_cnt_q == cnt_q)) begin
        res_status_d = ST_NOTFOUND;
      end
    end

    if (cmd_i.out_load) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_data_d   = res_data_q;
      out_slot_d   = SLOT_OUT_W'(res_slot_q);
      out_fill_d   = FILL_W'(cnt_q);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      cap_d  = cfg_v;
      head_d = '0;
      tail_d = '0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      cap_q       <= CAP_RST;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    val_q        <= val_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_slot_q   <= res_slot_d;
    scan_ptr_q   <= scan_ptr_d;
    scan_cnt_q   <= scan_cnt_d;
    pend_q       <= pend_d;
    pend_slot_q  <= pend_slot_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_slot_q   <= out_slot_d;
    out_fill_q   <= out_fill_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= val_q;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign cfg_rdata_o  = PDATA_W'(cap_q);
  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = out_data_q;
  assign out_slot_o   = out_slot_q;
  assign out_fill_o   = out_fill_q;

endmodule

FILE: rtl/ring_buffer_deque_with_search.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque_with_search: double-ended queue with linear search
// Signed 32-bit words in a ring store of programmable length; push and pop at
// both ends, peek, search for the first match from the front, and clear.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 payload
//  --------  ---  ------------------------  --------------------------------
//  s_axis    in   s_axis_tvalid/tready      tdata: value; tuser: func
//  m_axis    out  m_axis_tvalid/tready      tdata: data_out, slot_found,
//                                           fill_count; tuser: status
//  apb       in   psel & penable & pwrite   capacity at 0x0
//
//  Sequence: push, clear and refused items pass through the execute and
//  response states before m_axis_tvalid rises; pop and peek add a read-wait
//  state for the registered store read. Search walks from the front until the
//  first match or the end of the stored words (the walk reads one slot per
//  cycle through the single store read port).
//  One item is in flight at a time; s_axis_tready is high only while idle.
//  The output register holds a result while m_axis_tready is low, and the
//  next item is accepted meanwhile; its result waits until the register frees.
//  Reset empties the queue and sets capacity to 64, or to DEPTH if smaller;
//  the store needs no clear. Writing capacity also empties the queue.
//
module ring_buffer_deque_with_search import rbds_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // stream in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VALUE_W-1:0]    s_axis_tdata,   // [31:0] value
  input  logic [FUNC_W-1:0]     s_axis_tuser,   // [2:0] func
  // stream out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] data_out, [37:32] slot_found,
                                                // [44:38] fill_count, [47:45] zero
  output logic [STATUS_W-1:0]   m_axis_tuser,   // [1:0] status
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  ctrl_cmd_t             cmd;
  dp_stat_t              stat;
  logic                  cfg_hit;
  logic                  cfg_we;
  logic [PDATA_W-1:0]    cap_rdata;
  logic [STATUS_W-1:0]   out_status;
  logic [VALUE_W-1:0]    out_data;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic [FILL_W-1:0]     out_fill;

  // decode the word address; only the capacity register exists
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == REG_CAPACITY);
  assign cfg_we  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? cap_rdata : '0;

  rbds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rbds_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .func_i       (s_axis_tuser),
    .value_i      (s_axis_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (pwdata[CAP_W-1:0]),
    .cfg_rdata_o  (cap_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_data_o   (out_data),
    .out_slot_o   (out_slot),
    .out_fill_o   (out_fill)
  );

  // pack the result, zero fill to whole bytes
  assign m_axis_tdata = {(OUT_DATA_W - VALUE_W - SLOT_OUT_W - FILL_W)'(0),
                         out_fill, out_slot, out_data};
  assign m_axis_tuser = out_status;

endmodule

FILE: rtl/rbds_checker.sv
// ----------------------------------------------------------------------------
// rbds_checker: port-level checks of the ring buffer deque
// Watches the stream ports and flags inconsistent results or handshakes.
// ----------------------------------------------------------------------------
module rbds_checker import rbds_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [STATUS_W-1:0]   m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // one item at a time: no acceptance right after an acceptance
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while another is in flight");

  // an empty refusal reports no stored words and no data
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |->
      (m_axis_tdata[44:38] == '0) && (m_axis_tdata[31:0] == '0))
    else $error("empty status with data or nonzero count");

  // full refusal and failed search carry zero data; a miss carries slot zero
  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == ST_FULL) || (m_axis_tuser == ST_NOTFOUND)) |->
      (m_axis_tdata[31:0] == '0) && (m_axis_tdata[37:32] == '0))
    else $error("refused item returned data or a slot");

endmodule

bind ring_buffer_deque_with_search rbds_checker u_rbds_checker (.*);

FILE: verif/tb_ring_buffer_deque_with_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ring_buffer_deque_with_search: self-checking bench for the ring deque
// Sends deque operations on the input stream and capacity writes on the APB
// port. A mirror of the ring predicts each result item, and every item that
// comes out is compared field by field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ring_buffer_deque_with_search;
  import rbds_pkg::*;

  // func code outside the enum; the block answers it without touching state
  localparam logic [FUNC_W-1:0]  FN_UNUSED    = 3'd7;
  localparam logic [PADDR_W-1:0] CAP_ADDR     = {REG_CAPACITY, 2'b00};
  // settle time before a register write, and the pause at the end
  localparam int                 SETTLE_CYC   = 8;
  localparam int                 TAIL_CYC     = 80;
  localparam int                 PHASES       = 9;
  localparam int                 PHASE_ITEMS  = 100;

  typedef logic [SLOT_OUT_W-1:0] slot_t;
  typedef logic [FILL_W-1:0]     count_t;

  typedef struct {
    status_e              status;
    logic [VALUE_W-1:0]   data_out;
    slot_t                slot_found;
    count_t               fill_count;
  } deque_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block pins
  // --------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [VALUE_W-1:0]    s_axis_tdata;   // [31:0] value
  logic [FUNC_W-1:0]     s_axis_tuser;   // [2:0] func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [31:0] data_out, [37:32] slot_found,
                                         // [44:38] fill_count, [47:45] zero
  logic [STATUS_W-1:0]   m_axis_tuser;   // [1:0] status
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [PDATA_W-1:0]    pwdata;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  always #1 clk_i = ~clk_i;

  ring_buffer_deque_with_search #(
    .DEPTH(DEPTH_DEF)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // --------------------------------------------------------------------------
  // Mirror of the ring: store, front and back pointers, count and length
  // --------------------------------------------------------------------------
  logic [VALUE_W-1:0] ring_mirror [DEPTH_DEF];
  slot_t              front_slot;
  slot_t              back_slot;
  count_t             word_count;
  count_t             ring_len;

  deque_result_t      expected_results[$];
  int                 fail_count;
  int                 snd_idle_pct;
  int                 rcv_idle_pct;
  int                 stall_left;    // receiver hold-off, counted down per cycle
  bit                 fill_mode;     // bias random ops toward pushes when set

  function automatic slot_t slot_after(input slot_t s);
    return ({1'b0, s} + count_t'(1) >= ring_len) ? slot_t'(0) : s + slot_t'(1);
  endfunction

  function automatic slot_t slot_before(input slot_t s);
    return (s == '0) ? slot_t'(ring_len - count_t'(1)) : s - slot_t'(1);
  endfunction

  // Apply one operation to the mirror and return the result item it yields.
  function automatic deque_result_t deque_apply(input logic [FUNC_W-1:0] fn,
                                                input logic [VALUE_W-1:0] word);
    deque_result_t r;
    slot_t         s;
    bit            hit;
    r.status     = ST_OK;
    r.data_out   = '0;
    r.slot_found = '0;
    case (fn)
      FN_PUSH_REAR: begin
        if (word_count >= ring_len) begin
          r.status = ST_FULL;
        end else begin
          ring_mirror[back_slot] = word;
          back_slot = slot_after(back_slot);
          word_count++;
        end
      end
      FN_PUSH_FRONT: begin
        if (word_count >= ring_len) begin
          r.status = ST_FULL;
        end else begin
          front_slot = slot_before(front_slot);
          ring_mirror[front_slot] = word;
          word_count++;
        end
      end
      FN_POP_FRONT: begin
        if (word_count == '0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = ring_mirror[front_slot];
          front_slot = slot_after(front_slot);
          word_count--;
        end
      end
      FN_POP_REAR: begin
        if (word_count == '0) begin
          r.status = ST_EMPTY;
        end else begin
          back_slot = slot_before(back_slot);
          r.data_out = ring_mirror[back_slot];
          word_count--;
        end
      end
      FN_PEEK: begin
        if (word_count == '0) r.status = ST_EMPTY;
        else r.data_out = ring_mirror[front_slot];
      end
      FN_SEARCH: begin
        // walk from the front, stop at the first match
        hit = 1'b0;
        s   = front_slot;
        for (int i = 0; i < int'(word_count) && !hit; i++) begin
          if (ring_mirror[s] == word) begin
            hit = 1'b1;
            r.slot_found = s;
          end else begin
            s = slot_after(s);
          end
        end
        if (!hit) r.status = ST_NOTFOUND;
      end
      FN_CLEAR: begin
        word_count = '0;
        front_slot = '0;
        back_slot  = '0;
      end
      default: ;
    endcase
    r.fill_count = word_count;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Offer one item; leave tvalid high so back-to-back items need no toggle.
  task automatic issue_op(input logic [FUNC_W-1:0] fn, input logic [VALUE_W-1:0] word);
    if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(deque_apply(fn, word));
  endtask

  // Drop tvalid and hold until every predicted result has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Write capacity while idle; the write also empties the queue.
  task automatic write_capacity(input logic [PDATA_W-1:0] v);
    count_t len;
    drain_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // zero acts as one, anything above the store depth as the depth
    len = v[FILL_W-1:0];
    if (len == '0) len = count_t'(1);
    if (len > count_t'(DEPTH_DEF)) len = count_t'(DEPTH_DEF);
    ring_len   = len;
    word_count = '0;
    front_slot = '0;
    back_slot  = '0;
  endtask

  // Extremes, a small pool that forces duplicates, and plain random words.
  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4, 5:    return VALUE_W'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  // Mostly pushes while filling and pops while draining; flip at the ends.
  function automatic logic [FUNC_W-1:0] pick_op();
    int  roll;
    bit  major;
    roll = $urandom_range(99);
    if (word_count == '0) fill_mode = 1'b1;
    else if (word_count >= ring_len) fill_mode = 1'b0;
    else if ($urandom_range(19) == 0) fill_mode = !fill_mode;
    if (roll < 2) return FN_CLEAR;
    if (roll < 4) return FN_UNUSED;
    if (roll < 16) return FN_SEARCH;
    if (roll < 24) return FN_PEEK;
    major = (roll < 82);
    if (major == fill_mode) return $urandom_range(1) ? FN_PUSH_REAR : FN_PUSH_FRONT;
    return $urandom_range(1) ? FN_POP_REAR : FN_POP_FRONT;
  endfunction

  // Search mostly for a stored word so hits land at every depth.
  function automatic logic [VALUE_W-1:0] pick_operand(input logic [FUNC_W-1:0] fn);
    int k;
    if (fn == FN_SEARCH && word_count != '0 && $urandom_range(3) != 0) begin
      k = $urandom_range(int'(word_count) - 1);
      return ring_mirror[(int'(front_slot) + k) % int'(ring_len)];
    end
    return pick_word();
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Empty refusals, extreme words at both ends, every op, the unused code.
  task automatic test_empty_and_extremes();
    issue_op(FN_PEEK,       32'h0000_0000);
    issue_op(FN_POP_FRONT,  32'h0000_0000);
    issue_op(FN_POP_REAR,   32'h0000_0000);
    issue_op(FN_SEARCH,     32'h0000_0000);
    issue_op(FN_PUSH_REAR,  32'h8000_0000);
    issue_op(FN_PUSH_REAR,  32'h7FFF_FFFF);
    issue_op(FN_PUSH_FRONT, 32'h0000_0000);
    issue_op(FN_PUSH_FRONT, 32'hFFFF_FFFF);
    issue_op(FN_PEEK,       32'h5555_5555);
    issue_op(FN_SEARCH,     32'h7FFF_FFFF);
    issue_op(FN_SEARCH,     32'h8000_0000);
    issue_op(FN_SEARCH,     32'h1234_5678);
    issue_op(FN_UNUSED,     32'hAAAA_AAAA);
    issue_op(FN_POP_REAR,   32'h0000_0000);
    issue_op(FN_POP_FRONT,  32'h0000_0000);
    issue_op(FN_CLEAR,      32'hFFFF_FFFF);
    issue_op(FN_POP_FRONT,  32'h0000_0000);
    issue_op(FN_PUSH_REAR,  32'h5555_5555);
  endtask

  // Smallest rings: pointer wrap at both ends, full refusals, clamped writes.
  task automatic test_capacity_limits();
    write_capacity(32'd2);
    issue_op(FN_PUSH_FRONT, 32'd11);    // front wraps from slot 0 to the top
    issue_op(FN_PUSH_REAR,  32'd22);
    issue_op(FN_SEARCH,     32'd11);
    issue_op(FN_SEARCH,     32'd22);
    issue_op(FN_PUSH_REAR,  32'd33);
    issue_op(FN_POP_REAR,   32'd0);
    issue_op(FN_POP_REAR,   32'd0);     // back wraps from slot 0 to the top
    issue_op(FN_POP_FRONT,  32'd0);
    write_capacity(32'd1);
    issue_op(FN_PUSH_REAR,  32'd5);
    issue_op(FN_PUSH_FRONT, 32'd6);
    issue_op(FN_SEARCH,     32'd5);
    issue_op(FN_POP_REAR,   32'd0);
    issue_op(FN_PUSH_FRONT, 32'd6);
    issue_op(FN_PEEK,       32'd0);
    write_capacity(32'd0);              // acts as a ring of one
    issue_op(FN_PUSH_REAR,  32'd7);
    issue_op(FN_PUSH_REAR,  32'd8);
    write_capacity(32'd127);            // clamps to the store depth
    issue_op(FN_PUSH_FRONT, 32'd9);
    issue_op(FN_SEARCH,     32'd9);
  endtask

  // Fill the whole store, refuse at both ends, search the full depth, drain.
  task automatic test_full_ring();
    write_capacity(PDATA_W'(DEPTH_DEF));
    repeat (DEPTH_DEF)
      issue_op($urandom_range(1) ? FN_PUSH_REAR : FN_PUSH_FRONT, pick_word());
    issue_op(FN_PUSH_REAR,  32'h0BAD_F00D);
    issue_op(FN_PUSH_FRONT, 32'h0BAD_F00D);
    issue_op(FN_SEARCH,     ring_mirror[slot_before(back_slot)]);
    issue_op(FN_SEARCH,     32'h0BAD_F00D);
    repeat (DEPTH_DEF)
      issue_op($urandom_range(1) ? FN_POP_REAR : FN_POP_FRONT, pick_word());
    issue_op(FN_POP_REAR,   32'h0000_0000);
  endtask

  // Random fill/drain traffic on one ring length.
  task automatic test_random_mix(input int n_items, input logic [PDATA_W-1:0] cap_word);
    logic [FUNC_W-1:0] fn;
    write_capacity(cap_word);
    fill_mode = 1'b1;
    repeat (n_items) begin
      fn = pick_op();
      issue_op(fn, pick_operand(fn));
    end
  endtask

  // Hold the receiver off long enough that the block stalls its input.
  task automatic test_input_stall();
    logic [FUNC_W-1:0] fn;
    stall_left = 400;
    repeat (40) begin
      fn = pick_op();
      issue_op(fn, pick_operand(fn));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready, or a counted hold-off when one is requested
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result check: compare each accepted item with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    deque_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result item with no prediction waiting: tdata %h tuser %0d",
               m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata[31:0] !== want.data_out) begin
          $error("data_out: expected %h, got %h", want.data_out, m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tdata[37:32] !== want.slot_found) begin
          $error("slot_found: expected %0d, got %0d", want.slot_found,
                 m_axis_tdata[37:32]);
          fail_count++;
        end
        if (m_axis_tdata[44:38] !== want.fill_count) begin
          $error("fill_count: expected %0d, got %0d", want.fill_count,
                 m_axis_tdata[44:38]);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed tests, random phases, stall test, wind down
  // --------------------------------------------------------------------------
  initial begin
    logic [PDATA_W-1:0] phase_caps [PHASES];
    // short rings reach full often; one write carries junk above bit 6
    phase_caps = '{32'd1, 32'd2, 32'd3, 32'd100, 32'd7, 32'd0, 32'd16, 32'd63,
                   32'hFFFF_FF85};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    fail_count    = 0;
    stall_left    = 0;
    fill_mode     = 1'b1;
    snd_idle_pct  = 22;
    rcv_idle_pct  = 68;
    // mirror the reset state: empty queue, full-depth ring
    ring_len      = count_t'(CAP_RESET);
    word_count    = '0;
    front_slot    = '0;
    back_slot     = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_and_extremes();
    test_capacity_limits();
    test_full_ring();
    for (int p = 0; p < PHASES; p++) begin
      // slow receiver first, then slow sender, then both at full rate
      if (p == PHASES / 3) begin
        snd_idle_pct = 68;
        rcv_idle_pct = 22;
      end else if (p == 2 * PHASES / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      test_random_mix(PHASE_ITEMS, phase_caps[p]);
    end
    test_input_stall();

    drain_results();
    repeat (TAIL_CYC) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Stop a hung run: time out far past the slowest good run.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
